[sv/bsc_pkg.sv]
// Shared types, constants and helper functions for the barometric sensor compensation block.
// Used by the serial multiplier, the serial divider and the top level.
package bsc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CntW  = $clog2(DataW);

    localparam logic [31:0] TempOffset  = 32'd4000;
    localparam logic [31:0] HalfScale   = 32'd32768;
    localparam logic [31:0] PresScale   = 32'd50000;
    localparam logic [31:0] PresC1      = 32'd3038;
    localparam logic [31:0] PresC2      = 32'hFFFF_E343;
    localparam logic [31:0] PresC3      = 32'd3791;

    localparam logic [2:0] RegAc1Ac2 = 3'd0;
    localparam logic [2:0] RegAc3Ac4 = 3'd1;
    localparam logic [2:0] RegAc5Ac6 = 3'd2;
    localparam logic [2:0] RegB1B2   = 3'd3;
    localparam logic [2:0] RegMcMd   = 3'd4;

    localparam logic CmdTemp = 1'b0;
    localparam logic CmdPres = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] raw_sample;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
        logic               div_error;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic             done;
        logic [DataW-1:0] result;
    } t_unit_rsp;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

[sv/bsc_mul.sv]
// Bit-serial shift-and-add multiplier giving the low 32 bits of a product.
// One multiplier bit per cycle; depends on bsc_pkg.
module bsc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsc_pkg::t_unit_req i_req,
    output bsc_pkg::t_unit_rsp o_rsp
);
    import bsc_pkg::*;

    logic [DataW-1:0] r_a, n_a;
    logic [DataW-1:0] r_b, n_b;
    logic [DataW-1:0] r_acc, n_acc;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = {r_a[DataW-2:0], 1'b0};
            n_b   = {1'b0, r_b[DataW-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(DataW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

[sv/bsc_div.sv]
// Bit-serial restoring divider for unsigned 32-bit operands.
// One quotient bit per cycle; depends on bsc_pkg.
module bsc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsc_pkg::t_unit_req i_req,
    output bsc_pkg::t_unit_rsp o_rsp
);
    import bsc_pkg::*;

    logic [DataW-1:0] r_q, n_q;
    logic [DataW-1:0] r_rem, n_rem;
    logic [DataW-1:0] r_den, n_den;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DataW:0]   trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_q[DataW-1]};
        if (i_req.start) begin
            n_q    = i_req.a;
            n_den  = i_req.b;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DataW'(trial - {1'b0, r_den});
                n_q   = {r_q[DataW-2:0], 1'b1};
            end else begin
                n_rem = trial[DataW-1:0];
                n_q   = {r_q[DataW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(DataW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;

endmodule

[sv/barometric_sensor_compensation.sv]
// Each multiply or divide runs as load, 32 bit steps and done; a temperature item uses 2 of these
// in sequence and a pressure item 11. One item at a time: the next item can be taken in the cycle
// after the result is registered, and a stalled result holds the sequencer. Reset clears the
// calibration registers, the stored temperature term and all control state. Top level: sequencer
// and calibration registers; uses bsc_pkg, bsc_mul, bsc_div.
module barometric_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsc_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import bsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        ST_T_MUL, ST_T_DIV, ST_P_SQ, ST_P_X1, ST_P_B3, ST_P_AC3, ST_P_B1,
        ST_P_B4, ST_P_B7, ST_P_DIV, ST_P_PP, ST_P_C1, ST_P_FIN
    } t_step;

    t_state      r_state, n_state;
    t_step       r_step, n_step;
    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [31:0] r_temp_term, n_temp_term;
    logic        r_cmd, n_cmd;
    logic [15:0] r_raw, n_raw;
    logic [31:0] r_b6, n_b6;
    logic [31:0] r_sq, n_sq;
    logic [31:0] r_x1, n_x1;
    logic [31:0] r_t, n_t;
    logic [31:0] r_b3, n_b3;
    logic [31:0] r_b4, n_b4;
    logic [31:0] r_b7, n_b7;
    logic [31:0] r_p, n_p;
    logic [31:0] r_val, n_val;
    logic        r_err, n_err;
    logic        r_neg, n_neg;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_unit_req mul_req, div_req;
    t_unit_rsp mul_rsp, div_rsp;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] op_a, op_b, mcs, m, q, den, x1, x2, b5;
    logic        is_div, unit_done, in_acc;

    assign ac1 = {{16{r_c0[31]}}, r_c0[31:16]};
    assign ac2 = {{16{r_c0[15]}}, r_c0[15:0]};
    assign ac3 = {{16{r_c1[31]}}, r_c1[31:16]};
    assign ac4 = {16'b0, r_c1[15:0]};
    assign ac5 = {16'b0, r_c2[31:16]};
    assign ac6 = {16'b0, r_c2[15:0]};
    assign b1  = {{16{r_c3[31]}}, r_c3[31:16]};
    assign b2  = {{16{r_c3[15]}}, r_c3[15:0]};
    assign mc  = {{16{r_c4[31]}}, r_c4[31:16]};
    assign md  = {{16{r_c4[15]}}, r_c4[15:0]};
    assign mcs = {mc[20:0], 11'b0};

    assign is_div    = (r_step == ST_T_DIV) || (r_step == ST_P_DIV);
    assign unit_done = is_div ? div_rsp.done : mul_rsp.done;
    assign m         = mul_rsp.result;
    assign q         = div_rsp.result;
    assign in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step)
            ST_T_MUL: begin
                op_a = {16'b0, r_raw} - ac6;
                op_b = ac5;
            end
            ST_T_DIV: begin
                op_a = mcs[31] ? (32'd0 - mcs) : mcs;
                op_b = r_t[31] ? (32'd0 - r_t) : r_t;
            end
            ST_P_SQ: begin
                op_a = r_b6;
                op_b = r_b6;
            end
            ST_P_X1: begin
                op_a = b2;
                op_b = r_sq;
            end
            ST_P_B3: begin
                op_a = ac2;
                op_b = r_b6;
            end
            ST_P_AC3: begin
                op_a = ac3;
                op_b = r_b6;
            end
            ST_P_B1: begin
                op_a = b1;
                op_b = r_sq;
            end
            ST_P_B4: begin
                op_a = ac4;
                op_b = r_t;
            end
            ST_P_B7: begin
                op_a = {16'b0, r_raw} - r_b3;
                op_b = PresScale;
            end
            ST_P_DIV: begin
                op_a = r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0};
                op_b = r_b4;
            end
            ST_P_PP: begin
                op_a = asr32(r_p, 5'd8);
                op_b = asr32(r_p, 5'd8);
            end
            ST_P_C1: begin
                op_a = r_t;
                op_b = PresC1;
            end
            ST_P_FIN: begin
                op_a = PresC2;
                op_b = r_p;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_req.start = (r_state == S_LOAD) && !is_div;
    assign mul_req.a     = op_a;
    assign mul_req.b     = op_b;
    assign div_req.start = (r_state == S_LOAD) && is_div;
    assign div_req.a     = op_a;
    assign div_req.b     = op_b;

    bsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_temp_term = r_temp_term;
        n_cmd       = r_cmd;
        n_raw       = r_raw;
        n_b6        = r_b6;
        n_sq        = r_sq;
        n_x1        = r_x1;
        n_t         = r_t;
        n_b3        = r_b3;
        n_b4        = r_b4;
        n_b7        = r_b7;
        n_p         = r_p;
        n_val       = r_val;
        n_err       = r_err;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        x1          = asr32(m, 5'd15);
        den         = x1 + md;
        x2          = r_neg ? (32'd0 - q) : q;
        b5          = r_x1 + x2;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_in.cmd;
                    n_raw   = i_in.raw_sample;
                    n_b6    = r_temp_term - TempOffset;
                    n_step  = (i_in.cmd == CmdTemp) ? ST_T_MUL : ST_P_SQ;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_step == ST_T_DIV) begin
                    n_neg = mcs[31] ^ r_t[31];
                end
                n_state = S_RUN;
            end
            S_RUN: begin
                if (unit_done) begin
                    n_state = S_LOAD;
                    case (r_step)
                        ST_T_MUL: begin
                            n_x1 = x1;
                            n_t  = den;
                            if (den == '0) begin
                                n_val   = '0;
                                n_err   = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_step = ST_T_DIV;
                            end
                        end
                        ST_T_DIV: begin
                            n_temp_term = b5;
                            n_val       = asr32(b5 + 32'd8, 5'd4);
                            n_err       = 1'b0;
                            n_state     = S_DONE;
                        end
                        ST_P_SQ: begin
                            n_sq   = asr32(m, 5'd12);
                            n_step = ST_P_X1;
                        end
                        ST_P_X1: begin
                            n_t    = asr32(m, 5'd11);
                            n_step = ST_P_B3;
                        end
                        ST_P_B3: begin
                            n_b3   = asr32({ac1[29:0], 2'b0} + r_t + asr32(m, 5'd11) + 32'd2,
                                           5'd2);
                            n_step = ST_P_AC3;
                        end
                        ST_P_AC3: begin
                            n_t    = asr32(m, 5'd13);
                            n_step = ST_P_B1;
                        end
                        ST_P_B1: begin
                            n_t    = asr32(r_t + asr32(m, 5'd16) + 32'd2, 5'd2) + HalfScale;
                            n_step = ST_P_B4;
                        end
                        ST_P_B4: begin
                            n_b4 = {15'b0, m[31:15]};
                            if (m[31:15] == '0) begin
                                n_val   = '0;
                                n_err   = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_step = ST_P_B7;
                            end
                        end
                        ST_P_B7: begin
                            n_b7   = m;
                            n_step = ST_P_DIV;
                        end
                        ST_P_DIV: begin
                            n_p    = r_b7[31] ? {q[30:0], 1'b0} : q;
                            n_step = ST_P_PP;
                        end
                        ST_P_PP: begin
                            n_t    = m;
                            n_step = ST_P_C1;
                        end
                        ST_P_C1: begin
                            n_t    = asr32(m, 5'd16);
                            n_step = ST_P_FIN;
                        end
                        ST_P_FIN: begin
                            n_val   = r_p + asr32(r_t + asr32(m, 5'd16) + PresC3, 5'd4);
                            n_err   = 1'b0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = r_cmd;
                    n_out.value     = r_val;
                    n_out.div_error = r_err;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_T_MUL;
            r_out_valid <= 1'b0;
            r_temp_term <= '0;
            r_c0        <= '0;
            r_c1        <= '0;
            r_c2        <= '0;
            r_c3        <= '0;
            r_c4        <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_temp_term <= n_temp_term;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegAc1Ac2: r_c0 <= i_cfg_data;
                    RegAc3Ac4: r_c1 <= i_cfg_data;
                    RegAc5Ac6: r_c2 <= i_cfg_data;
                    RegB1B2:   r_c3 <= i_cfg_data;
                    RegMcMd:   r_c4 <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_cmd <= n_cmd;
        r_raw <= n_raw;
        r_b6  <= n_b6;
        r_sq  <= n_sq;
        r_x1  <= n_x1;
        r_t   <= n_t;
        r_b3  <= n_b3;
        r_b4  <= n_b4;
        r_b7  <= n_b7;
        r_p   <= n_p;
        r_val <= n_val;
        r_err <= n_err;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("both arithmetic units started together");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LOAD))
        else $error("accepted item did not start the sequencer");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.div_error) |-> (o_out.value == '0))
        else $error("divisor error with nonzero value");

    a_no_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.b != '0))
        else $error("divider started with zero divisor");

endmodule

[bench/barometric_sensor_compensation_tb.sv]
// Self-checking testbench for the barometric sensor compensation block.
// Predicts each temperature and pressure result in SystemVerilog and compares it; uses bsc_pkg.
module barometric_sensor_compensation_tb;
    import bsc_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;
    logic      i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    barometric_sensor_compensation uut (.*);

    always #4 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_readings[$];
    logic [31:0] cal_regs[5];
    logic [31:0] b5_term;
    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;
    logic o_in_ready_q = 1'b0;

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_out_item compensate(input t_in_item it);
        t_out_item r;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
        r.kind = it.cmd;
        r.div_error = 1'b0;
        r.value = '0;
        if (it.cmd == CmdTemp) begin
            x1 = sra(({16'd0, it.raw_sample} - {16'd0, cal_regs[RegAc5Ac6][15:0]})
                     * {16'd0, cal_regs[RegAc5Ac6][31:16]}, 15);
            den = x1 + sx(cal_regs[RegMcMd][15:0]);
            if (den == 0) begin
                r.div_error = 1'b1;
            end else begin
                x2 = quot(sx(cal_regs[RegMcMd][31:16]) << 11, den);
                b5 = x1 + x2;
                b5_term = b5;
                r.value = sra(b5 + 32'd8, 4);
            end
        end else begin
            b6 = b5_term - TempOffset;
            sq = sra(b6 * b6, 12);
            x1 = sra(sx(cal_regs[RegB1B2][15:0]) * sq, 11);
            x2 = sra(sx(cal_regs[RegAc1Ac2][15:0]) * b6, 11);
            x3 = x1 + x2;
            b3 = sra(sx(cal_regs[RegAc1Ac2][31:16]) * 32'd4 + x3 + 32'd2, 2);
            x1 = sra(sx(cal_regs[RegAc3Ac4][31:16]) * b6, 13);
            x2 = sra(sx(cal_regs[RegB1B2][31:16]) * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = ({16'd0, cal_regs[RegAc3Ac4][15:0]} * (x3 + HalfScale)) >> 15;
            if (b4 == 0) begin
                r.div_error = 1'b1;
            end else begin
                b7 = ({16'd0, it.raw_sample} - b3) * PresScale;
                if (!b7[31]) p = (b7 << 1) / b4;
                else p = (b7 / b4) << 1;
                x1 = sra(p, 8);
                x1 = x1 * x1;
                x1 = sra(x1 * PresC1, 16);
                x2 = sra(PresC2 * p, 16);
                r.value = p + sra(x1 + x2 + PresC3, 4);
            end
        end
        return r;
    endfunction

    // Driver: presents queued items at the falling edge and predicts on acceptance.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready_q) begin
                expected_readings.push_back(compensate(i_in));
                void'(pending_items.pop_front());
            end
            if ((!i_in_valid || o_in_ready_q) && pending_items.size() > 0
                    && (calm || $urandom_range(99) >= 19)) begin
                i_in_valid <= 1'b1;
                i_in <= pending_items[0];
            end else if (!i_in_valid || o_in_ready_q) begin
                i_in_valid <= 1'b0;
            end
            i_out_ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // Monitor: records the input handshake and checks results at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        o_in_ready_q <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                errors++;
            end else begin
                if (o_out.kind !== expected_readings[0].kind)
                    $display("%0t: kind expected %0d actual %0d", $time,
                             expected_readings[0].kind, o_out.kind);
                if (o_out.value !== expected_readings[0].value)
                    $display("%0t: value expected %0d actual %0d", $time,
                             expected_readings[0].value, o_out.value);
                if (o_out.div_error !== expected_readings[0].div_error)
                    $display("%0t: div_error expected %0d actual %0d", $time,
                             expected_readings[0].div_error, o_out.div_error);
                if (o_out !== expected_readings[0]) errors++;
                void'(expected_readings.pop_front());
            end
        end
        if (cycles > 2000000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_readings.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cal(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        cal_regs[idx] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_item(input logic cmd, input logic [15:0] raw);
        t_in_item it;
        it.cmd = cmd;
        it.raw_sample = raw;
        pending_items.push_back(it);
    endtask

    // Calibration sets: typical, all zero, all ones, extremes and random.
    task automatic load_set(input int set_no);
        logic [31:0] v[5];
        case (set_no)
            0: v = '{32'h01980000 | 32'hFFFFFFB8 & 32'hFFFF, 32'hFFC77D1C, 32'h7EB45F47,
                     32'h185C0004, 32'hD4BD0B4B};
            1: v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
            2: v = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
            3: v = '{32'h80007FFF, 32'h7FFF8000, 32'hFFFF0000, 32'h80007FFF, 32'h80000000};
            default: for (int k = 0; k < 5; k++) v[k] = $urandom;
        endcase
        for (int k = 0; k < 5; k++) write_cal(k[2:0], v[k]);
    endtask

    initial begin
        for (int k = 0; k < 5; k++) cal_regs[k] = '0;
        b5_term = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Pressure before any temperature, and a zero divisor with the reset registers.
        queue_item(CmdPres, 16'h1234);
        queue_item(CmdTemp, 16'h0000);
        drain();
        load_set(0);
        calm = 1'b1;
        queue_item(CmdTemp, 16'h6C0B);
        queue_item(CmdPres, 16'h5D23);
        queue_item(CmdTemp, 16'h0000);
        queue_item(CmdTemp, 16'hFFFF);
        queue_item(CmdPres, 16'h0000);
        queue_item(CmdPres, 16'hFFFF);
        queue_item(CmdPres, 16'h8000);
        drain();
        calm = 1'b0;
        for (int s = 1; s < 12; s++) begin
            load_set(s);
            for (int n = 0; n < 5; n++) begin
                queue_item(CmdTemp, 16'($urandom));
                queue_item(CmdPres, 16'($urandom));
            end
            drain();
        end
        for (int s = 0; s < 10; s++) begin
            load_set(s == 0 ? 0 : 4 + s);
            calm = (s == 3);
            for (int n = 0; n < 44; n++) begin
                if ($urandom_range(9) < 3)
                    queue_item(CmdTemp, 16'(16'h5000 + $urandom_range(16'h3000)));
                else if ($urandom_range(9) < 8)
                    queue_item(CmdPres, 16'(16'h4000 + $urandom_range(16'h4000)));
                else queue_item(1'($urandom_range(1)), 16'($urandom));
            end
            drain();
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[files.f]
sv/bsc_pkg.sv
sv/bsc_mul.sv
sv/bsc_div.sv
sv/barometric_sensor_compensation.sv
bench/barometric_sensor_compensation_tb.sv
